/* hw/rtl/assert_macros.svh */
// Concurrent assertion helpers, clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

/* hw/rtl/sht_pkg.sv */
package sht_pkg;

  localparam int unsigned DataBits = 32;
  localparam int unsigned HashSteps = 4;
  localparam int unsigned HashBitsPerStep = 8;

  typedef enum logic [1:0] {
    KIND_ENTER = 2'd0,
    KIND_LOOK  = 2'd1,
    KIND_SET   = 2'd2,
    KIND_POP   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_KEY  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    kind_e                kind;
    logic [DataBits-1:0]  key;
    logic [DataBits-1:0]  value;
  } sht_req_t;

  typedef struct packed {
    status_e              status;
    logic [DataBits-1:0]  result_value;
  } sht_rsp_t;

  typedef struct packed {
    logic    clear;
    logic    load;
    logic    hash_step;
    logic    head_rd;
    logic    enter_commit;
    logic    pop_rd;
    logic    pop_commit;
    logic    link_load;
    logic    walk_rd;
    logic    link_next;
    logic    set_write;
    logic    finish;
    logic    result_sel;
    status_e status;
  } sht_cmd_t;

  typedef struct packed {
    kind_e req_kind;
    logic  req_key_zero;
    logic  empty;
    logic  full;
    logic  clear_last;
    logic  hash_last;
    kind_e kind;
    logic  link_ok;
    logic  key_match;
  } sht_sts_t;

endpackage

/* hw/rtl/sht_ctrl.sv */
`include "assert_macros.svh"

module sht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sht_pkg::sht_sts_t sts_i,
  output sht_pkg::sht_cmd_t cmd_o,
  output logic              busy_o
);
  import sht_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_HASH  = 8'b0000_0100,
    S_HEAD  = 8'b0000_1000,
    S_HEADW = 8'b0001_0000,
    S_WALK  = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_POP   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    busy_o  = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.req_kind == KIND_POP) begin
            if (sts_i.empty) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.pop_rd = 1'b1;
              state_d = S_POP;
            end
          end else if (sts_i.req_key_zero) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_ZERO_KEY;
          end else if (sts_i.req_kind == KIND_ENTER && sts_i.full) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_FULL;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd_o.head_rd = 1'b1;
        state_d = S_HEADW;
      end
      S_HEADW: begin
        if (sts_i.kind == KIND_ENTER) begin
          cmd_o.enter_commit = 1'b1;
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.link_load = 1'b1;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (!sts_i.link_ok) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_NOT_FOUND;
          state_d = S_IDLE;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.key_match) begin
          cmd_o.finish = 1'b1;
          if (sts_i.kind == KIND_LOOK) begin
            cmd_o.result_sel = 1'b1;
          end else begin
            cmd_o.set_write = 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          cmd_o.link_next = 1'b1;
          state_d = S_WALK;
        end
      end
      S_POP: begin
        cmd_o.pop_commit = 1'b1;
        cmd_o.finish = 1'b1;
        cmd_o.result_sel = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_accept_leaves_idle, (cmd_o.load && !cmd_o.finish) |=> (state_q != S_IDLE), "accepted item did not start work")

endmodule

/* hw/rtl/sht_dp.sv */
`include "assert_macros.svh"

module sht_dp #(
  parameter int unsigned BUCKETS  = 128,
  parameter int unsigned ENTRIES  = 1024,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sht_pkg::sht_req_t req_i,
  input  sht_pkg::sht_cmd_t cmd_i,
  output sht_pkg::sht_sts_t sts_o,
  output sht_pkg::sht_rsp_t rsp_o,
  output logic              done_o
);
  import sht_pkg::*;

  localparam int unsigned KW = (KEY_BITS < DataBits) ? KEY_BITS : DataBits;
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [KW-1:0]       entry_key_mem    [ENTRIES];
  logic [DataBits-1:0] entry_value_mem  [ENTRIES];
  logic [CW-1:0]       entry_next_mem   [ENTRIES];
  logic [BW-1:0]       entry_bucket_mem [ENTRIES];
  logic [CW-1:0]       bucket_head_mem  [BUCKETS];

  kind_e               kind_q;
  logic [KW-1:0]       key_q;
  logic [DataBits-1:0] value_q;
  logic [BW-1:0]       rem_q, rem_d;
  logic [DataBits-1:0] key_sh_q;
  logic [1:0]          hcnt_q;
  logic [CW-1:0]       link_q;
  logic [CW-1:0]       count_q;
  logic [BW-1:0]       clr_q;
  sht_rsp_t            rsp_q;
  logic                done_q;

  logic [KW-1:0]       ent_key_q;
  logic [DataBits-1:0] ent_value_q;
  logic [CW-1:0]       ent_next_q;
  logic [BW-1:0]       ent_bucket_q;
  logic [CW-1:0]       head_rd_q;

  logic [KW-1:0]       req_key;
  logic [CW-1:0]       count_m1;
  logic [CW-1:0]       link_m1;
  logic [AW-1:0]       ent_addr;
  logic                ent_we;
  logic                val_we;
  logic [BW-1:0]       head_addr;
  logic                head_we;
  logic [CW-1:0]       head_wd;

  assign req_key  = req_i.key[KW-1:0];
  assign count_m1 = count_q - CW'(1);
  assign link_m1  = link_q - CW'(1);

  // Remainder by BUCKETS, eight key bits per step, most significant first.
  always_comb begin
    logic [BW:0]   t;
    logic [BW-1:0] r;
    r = rem_q;
    for (int i = 0; i < int'(HashBitsPerStep); i++) begin
      t = {r, key_sh_q[DataBits-1-i]};
      if (t >= (BW+1)'(BUCKETS)) begin
        t = t - (BW+1)'(BUCKETS);
      end
      r = t[BW-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= req_i.kind;
      key_q    <= req_key;
      value_q  <= req_i.value;
      rem_q    <= '0;
      key_sh_q <= DataBits'(req_key);
    end else if (cmd_i.hash_step) begin
      rem_q    <= rem_d;
      key_sh_q <= key_sh_q << HashBitsPerStep;
    end
    if (cmd_i.link_load) begin
      link_q <= head_rd_q;
    end else if (cmd_i.link_next) begin
      link_q <= ent_next_q;
    end
    if (cmd_i.finish) begin
      rsp_q.status       <= cmd_i.status;
      rsp_q.result_value <= cmd_i.result_sel ? ent_value_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      clr_q   <= '0;
      hcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.clear) begin
        clr_q <= clr_q + BW'(1);
      end
      if (cmd_i.load) begin
        hcnt_q <= '0;
      end else if (cmd_i.hash_step) begin
        hcnt_q <= hcnt_q + 2'd1;
      end
      if (cmd_i.enter_commit) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.pop_commit) begin
        count_q <= count_m1;
      end
    end
  end

  always_comb begin
    if (cmd_i.enter_commit) begin
      ent_addr = count_q[AW-1:0];
    end else if (cmd_i.pop_rd) begin
      ent_addr = count_m1[AW-1:0];
    end else begin
      ent_addr = link_m1[AW-1:0];
    end
  end

  assign ent_we = cmd_i.enter_commit;
  assign val_we = cmd_i.enter_commit | cmd_i.set_write;

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      entry_key_mem[ent_addr]    <= key_q;
      entry_next_mem[ent_addr]   <= head_rd_q;
      entry_bucket_mem[ent_addr] <= rem_q;
    end
    if (val_we) begin
      entry_value_mem[ent_addr] <= value_q;
    end
    ent_key_q    <= entry_key_mem[ent_addr];
    ent_value_q  <= entry_value_mem[ent_addr];
    ent_next_q   <= entry_next_mem[ent_addr];
    ent_bucket_q <= entry_bucket_mem[ent_addr];
  end

  always_comb begin
    head_addr = rem_q;
    head_we   = 1'b0;
    head_wd   = '0;
    if (cmd_i.clear) begin
      head_addr = clr_q;
      head_we   = 1'b1;
    end else if (cmd_i.enter_commit) begin
      head_we = 1'b1;
      head_wd = count_q + CW'(1);
    end else if (cmd_i.pop_commit) begin
      head_addr = ent_bucket_q;
      head_we   = 1'b1;
      head_wd   = ent_next_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      bucket_head_mem[head_addr] <= head_wd;
    end
    head_rd_q <= bucket_head_mem[head_addr];
  end

  always_comb begin
    sts_o.req_kind     = req_i.kind;
    sts_o.req_key_zero = (req_key == '0);
    sts_o.empty        = (count_q == '0);
    sts_o.full         = (count_q >= CW'(ENTRIES));
    sts_o.clear_last   = (clr_q == BW'(BUCKETS - 1));
    sts_o.hash_last    = (hcnt_q == 2'(HashSteps - 1));
    sts_o.kind         = kind_q;
    sts_o.link_ok      = (link_q != '0) && (link_q <= count_q);
    sts_o.key_match    = (ent_key_q == key_q);
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

  `ASSERT_NEVER(a_count_bound, count_q > CW'(ENTRIES), "binding count beyond capacity")
  `ASSERT_NEVER(a_push_pop_excl, cmd_i.enter_commit && cmd_i.pop_commit, "push and pop together")
  `ASSERT_CLK(a_pop_count, cmd_i.pop_commit |=> (count_q == $past(count_q) - CW'(1)), "pop did not drop count")

endmodule

/* hw/rtl/scoped_hash_symbol_table_core.sv */
// A rejected item's result strobe comes in the next cycle; pop first passes the pop state.
// Enter runs the hash remainder steps, head read and head wait; look or set go on to the walk and
// compare states per chain entry until a match or the chain end, one entry memory read each.
// One item at a time; a new transfer is taken in the cycle its predecessor's result shows.
// After reset the bucket heads are cleared, one per cycle, with busy high.
// Results are never held off by the receiver.
module scoped_hash_symbol_table_core #(
  parameter int unsigned BUCKETS  = 128,
  parameter int unsigned ENTRIES  = 1024,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sht_pkg::sht_req_t req_i,
  output logic              done_o,
  output sht_pkg::sht_rsp_t rsp_o
);
  import sht_pkg::*;

  sht_cmd_t cmd;
  sht_sts_t sts;

  sht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  sht_dp #(
    .BUCKETS  (BUCKETS),
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule

/* verif/tb_scoped_hash_symbol_table_core.sv */
`timescale 1ns / 100ps

module tb_scoped_hash_symbol_table_core;
  import sht_pkg::*;

  localparam int unsigned NUM_BUCKETS = 128;
  localparam int unsigned NUM_ENTRIES = 1024;
  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned POOL_SIZE   = 48;

  class binding_stack_model;
    int unsigned bucket_head [NUM_BUCKETS];
    bit [31:0]   slot_key    [NUM_ENTRIES];
    bit [31:0]   slot_value  [NUM_ENTRIES];
    int unsigned slot_next   [NUM_ENTRIES];
    int unsigned depth;
    int unsigned peak_depth;
    sht_rsp_t    pending_rsp [$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned responses;
    int unsigned full_hits;
    int unsigned empty_hits;
    int unsigned miss_hits;

    function int unsigned newest_link(bit [31:0] k);
      int unsigned link;
      int unsigned steps;
      link  = bucket_head[k % NUM_BUCKETS];
      steps = 0;
      while (link != 0 && link <= depth && steps < NUM_ENTRIES) begin
        if (slot_key[link-1] == k) return link;
        link = slot_next[link-1];
        steps++;
      end
      return 0;
    endfunction

    function void note_request(sht_req_t r);
      sht_rsp_t    rsp;
      int unsigned link;
      int unsigned b;
      rsp.status       = ST_OK;
      rsp.result_value = '0;
      requests++;
      if (r.kind == KIND_POP) begin
        if (depth == 0) begin
          rsp.status = ST_EMPTY;
          empty_hits++;
        end else begin
          depth--;
          bucket_head[slot_key[depth] % NUM_BUCKETS] = slot_next[depth];
          rsp.result_value = slot_value[depth];
        end
      end else if (r.key == '0) begin
        rsp.status = ST_ZERO_KEY;
      end else if (r.kind == KIND_ENTER) begin
        if (depth >= NUM_ENTRIES) begin
          rsp.status = ST_FULL;
          full_hits++;
        end else begin
          b = r.key % NUM_BUCKETS;
          slot_key[depth]   = r.key;
          slot_value[depth] = r.value;
          slot_next[depth]  = bucket_head[b];
          depth++;
          bucket_head[b] = depth;
          if (depth > peak_depth) peak_depth = depth;
        end
      end else begin
        link = newest_link(r.key);
        if (link == 0) begin
          rsp.status = ST_NOT_FOUND;
          miss_hits++;
        end else if (r.kind == KIND_LOOK) begin
          rsp.result_value = slot_value[link-1];
        end else begin
          slot_value[link-1] = r.value;
        end
      end
      pending_rsp.push_back(rsp);
    endfunction

    function void check_response(sht_rsp_t got);
      sht_rsp_t want;
      responses++;
      if (pending_rsp.size() == 0) begin
        $error("result with nothing outstanding: status %0d, result_value %h",
               got.status, got.result_value);
        mismatches++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %h, got %h", want.result_value, got.result_value);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  sht_req_t req;
  logic     done;
  sht_rsp_t rsp;

  binding_stack_model model;
  bit [31:0]          key_pool [POOL_SIZE];
  int unsigned        burst_left;
  int unsigned        idle_cycles;

  scoped_hash_symbol_table_core #(
    .BUCKETS (NUM_BUCKETS),
    .ENTRIES (NUM_ENTRIES),
    .KEY_BITS(32)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done),
    .rsp_o (rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done) model.check_response(rsp);
      if (start && !busy) model.note_request(req);
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic issue(sht_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic op(kind_e k, logic [31:0] key, logic [31:0] value);
    sht_req_t r;
    r.kind  = k;
    r.key   = key;
    r.value = value;
    issue(r);
  endtask

  function automatic bit [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return '0;
    if (sel < 15) return $urandom();
    if (sel < 18) return 32'hFFFF_FFFF;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic bit [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic run_mix(int unsigned n, int unsigned enter_pct, int unsigned pop_pct);
    int unsigned sel;
    kind_e       k;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < enter_pct)                 k = KIND_ENTER;
      else if (sel < enter_pct + pop_pct)  k = KIND_POP;
      else if ($urandom_range(0, 4) < 3)   k = KIND_LOOK;
      else                                 k = KIND_SET;
      op(k, pick_key(), pick_value());
    end
  endtask

  initial begin
    bit [31:0] k;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req         = '0;
    burst_left  = 0;
    idle_cycles = 0;
    model       = new;
    for (int i = 0; i < POOL_SIZE; i++) begin
      k      = $urandom();
      k[6:0] = 7'($urandom_range(0, 11) * 10);
      if (k == '0) k = 32'h0000_0100;
      key_pool[i] = k;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    op(KIND_POP,   $urandom(),   $urandom());
    op(KIND_LOOK,  32'h1,        $urandom());
    op(KIND_SET,   32'h1,        32'h1234_5678);
    op(KIND_ENTER, 32'h0,        32'hFFFF_FFFF);
    op(KIND_LOOK,  32'h0,        32'h0);
    op(KIND_SET,   32'h0,        32'hFFFF_FFFF);
    op(KIND_ENTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    op(KIND_ENTER, 32'h0000_007F, 32'h0);
    op(KIND_LOOK,  32'hFFFF_FFFF, 32'h0);
    op(KIND_LOOK,  32'h0000_017F, 32'h0);
    op(KIND_ENTER, 32'h5,        32'hA5A5_A5A5);
    op(KIND_ENTER, 32'h5,        32'h5A5A_5A5A);
    op(KIND_LOOK,  32'h5,        $urandom());
    op(KIND_SET,   32'h5,        32'hDEAD_BEEF);
    op(KIND_LOOK,  32'h5,        32'h0);
    op(KIND_POP,   $urandom(),   $urandom());
    op(KIND_LOOK,  32'h5,        32'h0);
    op(KIND_SET,   32'h0000_0080, 32'h1);
    op(KIND_ENTER, 32'h8000_0000, 32'h1);
    op(KIND_LOOK,  32'h8000_0000, 32'hFFFF_FFFF);
    repeat (5) op(KIND_POP, $urandom(), $urandom());

    run_mix(200, 40, 30);
    while (model.depth < NUM_ENTRIES) run_mix(1, 90, 0);
    run_mix(20, 70, 5);
    run_mix(420, 15, 55);
    run_mix(10, 10, 60);

    @(negedge clk_i);
    start <= 1'b0;
    while (model.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d transfers, %0d results; stack peaked at %0d of %0d",
             model.requests, model.responses, model.peak_depth, NUM_ENTRIES);
    $display("answers seen: %0d full, %0d empty, %0d not found",
             model.full_hits, model.empty_hits, model.miss_hits);
    if (model.mismatches == 0 && model.pending_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
